// ----- rtl/ecvs_pkg.sv -----
// Shared types, constants and helpers for the clock victim selector.
// No dependencies; used by every module of the block but ecvs_ram.
package ecvs_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    localparam int FC_W       = 9;
    localparam int FRAME_W    = 8;
    localparam int VICTIM_W   = 8;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [APB_AW-3:0] REG_FRAME_COUNT = '0;

    localparam int ENT_W   = 3;
    localparam int BIT_REF = 2;
    localparam int BIT_OCC = 1;
    localparam int BIT_DTY = 0;

    typedef enum logic [1:0] {
        OP_SET_REF   = 2'd0,
        OP_CLR_REF   = 2'd1,
        OP_WR_STATUS = 2'd2,
        OP_SELECT    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OC_ACK      = 3'd0,
        OC_CLEAN1   = 3'd1,
        OC_DIRTY    = 3'd2,
        OC_CLEAN2   = 3'd3,
        OC_FALLBACK = 3'd4,
        OC_NONE     = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_PASS1 = 2'd1,
        ST_PASS2 = 2'd2,
        ST_CLEAR = 2'd3
    } state_t;

    typedef struct packed {
        logic [FC_W-1:0] frame_count;
        logic            clr;
    } cfg_t;

    function automatic logic [ADDR_W-1:0] next_frame(
        input logic [ADDR_W-1:0] idx,
        input logic [CNT_W-1:0]  cnt
    );
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(idx) + CNT_W'(1);
        return (nx >= cnt) ? '0 : ADDR_W'(nx);
    endfunction

endpackage

// ----- rtl/ecvs_ram.sv -----
// Generic single-port-write, single-port-read RAM with per-bit write mask.
// Read data registered. No dependencies.
module ecvs_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 3
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wmask,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int b = 0; b < WIDTH; b++)
            begin
                if (wmask[b])
                begin
                    mem[waddr][b] <= wdata[b];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/ecvs_cfg.sv -----
// APB register file holding frame_count; raises a clear strobe on each frame_count write.
// Depends on ecvs_pkg.
module ecvs_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ecvs_pkg::APB_AW-1:0]   paddr,
    input  logic [ecvs_pkg::APB_DW-1:0]   pwdata,
    output logic [ecvs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output ecvs_pkg::cfg_t                cfg
);

    logic [ecvs_pkg::FC_W-1:0]     frame_count_reg;
    logic [ecvs_pkg::FC_W-1:0]     frame_count_next;
    logic [ecvs_pkg::APB_AW-3:0]   reg_idx;
    logic                          wr_hit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ecvs_pkg::APB_AW-1:2];
    assign wr_hit  = psel && penable && pwrite && (reg_idx == ecvs_pkg::REG_FRAME_COUNT);

    always_comb
    begin
        frame_count_next = frame_count_reg;
        if (wr_hit)
        begin
            frame_count_next = pwdata[ecvs_pkg::FC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == ecvs_pkg::REG_FRAME_COUNT)
        begin
            prdata = ecvs_pkg::APB_DW'(frame_count_reg);
        end
    end

    assign cfg.frame_count = frame_count_reg;
    assign cfg.clr         = wr_hit;

endmodule

// ----- rtl/ecvs_core.sv -----
// Request sequencer: frame-bit updates, clearing pass, two-pass clock scan over
// the frame RAM, clock hand and result register. Depends on ecvs_pkg, ecvs_ram.
module ecvs_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ecvs_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [ecvs_pkg::FRAME_W-1:0]  frame,
    input  logic                          occupied,
    input  logic                          dirty,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ecvs_pkg::VICTIM_W-1:0] victim,
    output logic [2:0]                    outcome
);

    localparam int AW = ecvs_pkg::ADDR_W;
    localparam int CW = ecvs_pkg::CNT_W;
    localparam int NF = ecvs_pkg::MAX_FRAMES;

    ecvs_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic [CW-1:0]      issued_reg, issued_next;
    logic               ev_vld_reg, ev_vld_next;
    logic [AW-1:0]      ev_idx_reg, ev_idx_next;
    logic               ev_last_reg, ev_last_next;
    logic [AW-1:0]      start_reg, start_next;
    logic               have_cand_reg, have_cand_next;
    logic [AW-1:0]      cand_reg, cand_next;
    logic [AW-1:0]      hand_reg, hand_next;
    logic               out_valid_reg, out_valid_next;
    logic [ecvs_pkg::VICTIM_W-1:0] victim_reg, victim_next;
    ecvs_pkg::outcome_t outcome_reg, outcome_next;
    logic [AW-1:0]      clr_idx_reg, clr_idx_next;
    logic               clr_all_reg, clr_all_next;

    logic [CW-1:0]      count;
    logic               accept;
    ecvs_pkg::op_t      op_in;
    logic               fr_in_range;
    logic [AW-1:0]      fr_addr;
    logic [AW-1:0]      scan_origin;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ecvs_pkg::ENT_W-1:0] mem_wmask;
    logic [ecvs_pkg::ENT_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ecvs_pkg::ENT_W-1:0] mem_rdata;

    logic               e_ref, e_occ, e_dty;
    logic               ev_clean;
    logic               new_cand;
    logic               issue;

    assign count = (cfg.frame_count > ecvs_pkg::FC_W'(NF)) ? CW'(NF) : CW'(cfg.frame_count);
    assign op_in       = ecvs_pkg::op_t'(op);
    assign in_ready    = (state_reg == ecvs_pkg::ST_IDLE) && !cfg.clr
                         && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign fr_in_range = CW'(frame) < count;
    assign fr_addr     = AW'(frame);
    assign scan_origin = (CW'(hand_reg) >= count) ? '0 : hand_reg;

    assign e_ref    = mem_rdata[ecvs_pkg::BIT_REF];
    assign e_occ    = mem_rdata[ecvs_pkg::BIT_OCC];
    assign e_dty    = mem_rdata[ecvs_pkg::BIT_DTY];
    assign ev_clean = ev_vld_reg && e_occ && !e_ref && !e_dty;
    assign new_cand = ev_vld_reg && e_occ && !e_ref && e_dty && !have_cand_reg;
    assign issue    = (state_reg inside {ecvs_pkg::ST_PASS1, ecvs_pkg::ST_PASS2})
                      && (issued_reg != count);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ecvs_pkg::ST_IDLE:
            begin
                if (accept && op_in == ecvs_pkg::OP_SELECT && count != '0)
                begin
                    state_next = ecvs_pkg::ST_PASS1;
                end
            end
            ecvs_pkg::ST_PASS1:
            begin
                if (ev_clean)
                begin
                    state_next = ecvs_pkg::ST_IDLE;
                end
                else if (ev_vld_reg && ev_last_reg)
                begin
                    state_next = (have_cand_reg || new_cand) ? ecvs_pkg::ST_IDLE
                                                             : ecvs_pkg::ST_PASS2;
                end
            end
            ecvs_pkg::ST_PASS2:
            begin
                if (ev_clean || (ev_vld_reg && ev_last_reg))
                begin
                    state_next = ecvs_pkg::ST_IDLE;
                end
            end
            ecvs_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == AW'(NF - 1))
                begin
                    state_next = ecvs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ecvs_pkg::ST_IDLE;
            end
        endcase

        if (cfg.clr)
        begin
            state_next = ecvs_pkg::ST_CLEAR;
        end
    end

    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        issued_next    = issued_reg;
        ev_vld_next    = 1'b0;
        ev_idx_next    = rd_idx_reg;
        ev_last_next   = (issued_reg == count - CW'(1));
        start_next     = start_reg;
        have_cand_next = have_cand_reg;
        cand_next      = cand_reg;
        hand_next      = hand_reg;
        out_valid_next = out_valid_reg && !out_ready;
        victim_next    = victim_reg;
        outcome_next   = outcome_reg;
        clr_idx_next   = clr_idx_reg;
        clr_all_next   = clr_all_reg;
        mem_we         = 1'b0;
        mem_waddr      = fr_addr;
        mem_wmask      = '0;
        mem_wdata      = '0;
        mem_re         = issue;

        if (issue)
        begin
            rd_idx_next = ecvs_pkg::next_frame(rd_idx_reg, count);
            issued_next = issued_reg + CW'(1);
            ev_vld_next = (state_next == state_reg);
        end

        case (state_reg)
            ecvs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    victim_next    = '0;
                    outcome_next   = ecvs_pkg::OC_ACK;
                    if (op_in == ecvs_pkg::OP_SELECT)
                    begin
                        if (count == '0)
                        begin
                            outcome_next = ecvs_pkg::OC_NONE;
                        end
                        else
                        begin
                            out_valid_next = 1'b0;
                            start_next     = scan_origin;
                            hand_next      = scan_origin;
                            rd_idx_next    = scan_origin;
                            issued_next    = '0;
                            have_cand_next = 1'b0;
                        end
                    end
                    else if (fr_in_range)
                    begin
                        mem_we = 1'b1;
                        case (op_in)
                            ecvs_pkg::OP_SET_REF:
                            begin
                                mem_wmask[ecvs_pkg::BIT_REF] = 1'b1;
                                mem_wdata[ecvs_pkg::BIT_REF] = 1'b1;
                            end
                            ecvs_pkg::OP_CLR_REF:
                            begin
                                mem_wmask[ecvs_pkg::BIT_REF] = 1'b1;
                            end
                            default:
                            begin
                                mem_wmask[ecvs_pkg::BIT_OCC] = 1'b1;
                                mem_wmask[ecvs_pkg::BIT_DTY] = 1'b1;
                                mem_wdata[ecvs_pkg::BIT_OCC] = occupied;
                                mem_wdata[ecvs_pkg::BIT_DTY] = dirty;
                            end
                        endcase
                    end
                end
            end
            ecvs_pkg::ST_PASS1:
            begin
                if (new_cand)
                begin
                    have_cand_next = 1'b1;
                    cand_next      = ev_idx_reg;
                end
                if (ev_vld_reg && e_occ && e_ref)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ev_idx_reg;
                    mem_wmask[ecvs_pkg::BIT_REF] = 1'b1;
                end
                if (ev_clean)
                begin
                    out_valid_next = 1'b1;
                    victim_next    = ecvs_pkg::VICTIM_W'(ev_idx_reg);
                    outcome_next   = ecvs_pkg::OC_CLEAN1;
                    hand_next      = ecvs_pkg::next_frame(ev_idx_reg, count);
                end
                else if (ev_vld_reg && ev_last_reg)
                begin
                    if (have_cand_reg || new_cand)
                    begin
                        out_valid_next = 1'b1;
                        victim_next    = ecvs_pkg::VICTIM_W'(have_cand_reg ? cand_reg
                                                                           : ev_idx_reg);
                        outcome_next   = ecvs_pkg::OC_DIRTY;
                        hand_next      = ecvs_pkg::next_frame(
                                             have_cand_reg ? cand_reg : ev_idx_reg, count);
                    end
                    else
                    begin
                        rd_idx_next = start_reg;
                        issued_next = '0;
                        ev_vld_next = 1'b0;
                    end
                end
            end
            ecvs_pkg::ST_PASS2:
            begin
                if (ev_clean)
                begin
                    out_valid_next = 1'b1;
                    victim_next    = ecvs_pkg::VICTIM_W'(ev_idx_reg);
                    outcome_next   = ecvs_pkg::OC_CLEAN2;
                    hand_next      = ecvs_pkg::next_frame(ev_idx_reg, count);
                end
                else if (ev_vld_reg && ev_last_reg)
                begin
                    out_valid_next = 1'b1;
                    victim_next    = ecvs_pkg::VICTIM_W'(start_reg);
                    outcome_next   = ecvs_pkg::OC_FALLBACK;
                    hand_next      = start_reg;
                end
            end
            ecvs_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wmask[ecvs_pkg::BIT_REF] = 1'b1;
                if (clr_all_reg)
                begin
                    mem_wmask = '1;
                end
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(NF - 1))
                begin
                    clr_all_next = 1'b0;
                end
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase

        if (cfg.clr)
        begin
            hand_next    = '0;
            clr_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecvs_pkg::ST_CLEAR;
            issued_reg    <= '0;
            ev_vld_reg    <= 1'b0;
            have_cand_reg <= 1'b0;
            hand_reg      <= '0;
            out_valid_reg <= 1'b0;
            clr_idx_reg   <= '0;
            clr_all_reg   <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            ev_vld_reg    <= ev_vld_next;
            have_cand_reg <= have_cand_next;
            hand_reg      <= hand_next;
            out_valid_reg <= out_valid_next;
            clr_idx_reg   <= clr_idx_next;
            clr_all_reg   <= clr_all_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        ev_idx_reg  <= ev_idx_next;
        ev_last_reg <= ev_last_next;
        start_reg   <= start_next;
        cand_reg    <= cand_next;
        victim_reg  <= victim_next;
        outcome_reg <= outcome_next;
    end

    ecvs_ram #(
        .DEPTH (NF),
        .WIDTH (ecvs_pkg::ENT_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wmask (mem_wmask),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_idx_reg),
        .rdata (mem_rdata)
    );

    assign out_valid = out_valid_reg;
    assign victim    = victim_reg;
    assign outcome   = outcome_reg;

endmodule

// ----- rtl/enhanced_clock_victim_select.sv -----
// Enhanced second-chance clock victim selector: per-frame reference, occupied
// and dirty bits in one frame RAM, with a clock hand and an APB frame_count
// register (counts above 256 act as 256). Set reference, clear reference and
// status writes, and a select with no frames in use, answer in the cycle after
// the request is taken. A select walks the frames from the hand, one frame per
// cycle through the RAM's single read port, in a first pass and, when needed, a
// second pass. A new request is taken only once the scan is over and the previous
// answer has left. After reset and after every frame_count write a clearing pass
// over all 256 entries zeroes the RAM (only the reference bits on a write) and
// holds requests off. Writing frame_count also clears the hand.
// Depends on ecvs_pkg, ecvs_cfg, ecvs_core and ecvs_ram.
module enhanced_clock_victim_select (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ecvs_pkg::APB_AW-1:0]   paddr,
    input  logic [ecvs_pkg::APB_DW-1:0]   pwdata,
    output logic [ecvs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [ecvs_pkg::FRAME_W-1:0]  frame,
    input  logic                          occupied,
    input  logic                          dirty,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ecvs_pkg::VICTIM_W-1:0] victim,
    output logic [2:0]                    outcome
);

    ecvs_pkg::cfg_t cfg;

    ecvs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ecvs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .frame     (frame),
        .occupied  (occupied),
        .dirty     (dirty),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .victim    (victim),
        .outcome   (outcome)
    );

endmodule

// ----- sim/enhanced_clock_victim_select_tb.sv -----
// Testbench for enhanced_clock_victim_select: directed table, then random request
// segments at several frame counts, replies checked against an in-bench predictor.
// Depends on ecvs_pkg and the enhanced_clock_victim_select RTL.
module enhanced_clock_victim_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam int DIR_ROWS    = 32;
    localparam int SEGMENTS    = 12;

    typedef struct packed {
        logic [ecvs_pkg::VICTIM_W-1:0] victim;
        ecvs_pkg::outcome_t            outcome;
    } reply_t;

    typedef struct packed {
        bit                        is_cfg;
        logic [ecvs_pkg::FC_W-1:0] count;
        ecvs_pkg::op_t             req_op;
        logic [7:0]                req_frame;
        logic                      req_occ;
        logic                      req_dty;
        bit                        fixed;
        logic [7:0]                exp_victim;
        ecvs_pkg::outcome_t        exp_outcome;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{1'b0, 9'd0,   ecvs_pkg::OP_SELECT,    8'd0,   1'b0, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_NONE},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_WR_STATUS, 8'd255, 1'b1, 1'b1, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b1, 9'd4,   ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_WR_STATUS, 8'd0,   1'b1, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_WR_STATUS, 8'd1,   1'b1, 1'b1, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_WR_STATUS, 8'd2,   1'b1, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SELECT,    8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SELECT,    8'd200, 1'b1, 1'b1, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_WR_STATUS, 8'd4,   1'b1, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SELECT,    8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b1, 9'd256, ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_WR_STATUS, 8'd255, 1'b1, 1'b1, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_CLR_REF,   8'd255, 1'b0, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SELECT,    8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b1, 9'd511, ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SET_REF,   8'd255, 1'b0, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SELECT,    8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b1, 9'd1,   ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_WR_STATUS, 8'd0,   1'b1, 1'b1, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SELECT,    8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b1, 9'd2,   ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_WR_STATUS, 8'd0,   1'b1, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SET_REF,   8'd1,   1'b0, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SELECT,    8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b1, 9'd3,   ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_WR_STATUS, 8'd2,   1'b1, 1'b1, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SET_REF,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0, ecvs_pkg::OC_ACK},
        '{1'b0, 9'd0,   ecvs_pkg::OP_SELECT,    8'd0,   1'b0, 1'b0, 1'b0, 8'd0, ecvs_pkg::OC_ACK}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ecvs_pkg::APB_AW-1:0]   paddr;
    logic [ecvs_pkg::APB_DW-1:0]   pwdata;
    logic [ecvs_pkg::APB_DW-1:0]   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic [1:0]                    op;
    logic [ecvs_pkg::FRAME_W-1:0]  frame;
    logic                          occupied;
    logic                          dirty;
    logic                          out_valid;
    logic                          out_ready;
    logic [ecvs_pkg::VICTIM_W-1:0] victim;
    logic [2:0]                    outcome;

    bit                        ref_bit [ecvs_pkg::MAX_FRAMES];
    bit                        occ_bit [ecvs_pkg::MAX_FRAMES];
    bit                        dty_bit [ecvs_pkg::MAX_FRAMES];
    int                        clock_hand;
    logic [ecvs_pkg::FC_W-1:0] frame_count_reg;

    reply_t pending_replies [$];
    reply_t head;
    int     fail_cnt;
    int     quiet_cycles;
    int     sender_idle_pct;
    int     recv_stall_pct;
    int     hold_cycles;
    int     seg_counts [SEGMENTS] = '{2, 1, 5, 0, 8, 256, 3, 16, 511, 4, 33, 300};

    enhanced_clock_victim_select i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .frame     (frame),
        .occupied  (occupied),
        .dirty     (dirty),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .victim    (victim),
        .outcome   (outcome)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int active_frames();
        return (int'(frame_count_reg) > ecvs_pkg::MAX_FRAMES) ? ecvs_pkg::MAX_FRAMES
                                                              : int'(frame_count_reg);
    endfunction

    function automatic int wrap_frame(input int idx, input int cnt);
        return (idx + 1 >= cnt) ? 0 : idx + 1;
    endfunction

    function automatic reply_t predict_reply(input ecvs_pkg::op_t o, input logic [7:0] fr,
                                             input logic occ, input logic dty);
        reply_t r;
        int     cnt;
        int     start;
        int     idx;
        int     cand;
        int     vic;
        int     i;
        bit     have_cand;
        bit     done;
        r.victim  = '0;
        r.outcome = ecvs_pkg::OC_ACK;
        cnt       = active_frames();
        vic       = 0;
        have_cand = 1'b0;
        done      = 1'b0;
        cand      = 0;
        if (o != ecvs_pkg::OP_SELECT)
        begin
            if (int'(fr) < cnt)
            begin
                case (o)
                    ecvs_pkg::OP_SET_REF: ref_bit[fr] = 1'b1;
                    ecvs_pkg::OP_CLR_REF: ref_bit[fr] = 1'b0;
                    default:
                    begin
                        occ_bit[fr] = occ;
                        dty_bit[fr] = dty;
                    end
                endcase
            end
        end
        else if (cnt == 0)
        begin
            r.outcome = ecvs_pkg::OC_NONE;
        end
        else
        begin
            if (clock_hand >= cnt)
                clock_hand = 0;
            start = clock_hand;
            idx   = start;
            for (i = 0; i < cnt && !done; i++)
            begin
                if (occ_bit[idx])
                begin
                    if (!ref_bit[idx] && !dty_bit[idx])
                    begin
                        vic       = idx;
                        r.outcome = ecvs_pkg::OC_CLEAN1;
                        done      = 1'b1;
                    end
                    else if (!ref_bit[idx])
                    begin
                        if (!have_cand)
                        begin
                            have_cand = 1'b1;
                            cand      = idx;
                        end
                    end
                    else
                    begin
                        ref_bit[idx] = 1'b0;
                    end
                end
                idx = wrap_frame(idx, cnt);
            end
            if (!done && have_cand)
            begin
                vic       = cand;
                r.outcome = ecvs_pkg::OC_DIRTY;
                done      = 1'b1;
            end
            if (!done)
            begin
                idx = start;
                for (i = 0; i < cnt && !done; i++)
                begin
                    if (occ_bit[idx] && !ref_bit[idx] && !dty_bit[idx])
                    begin
                        vic       = idx;
                        r.outcome = ecvs_pkg::OC_CLEAN2;
                        done      = 1'b1;
                    end
                    idx = wrap_frame(idx, cnt);
                end
            end
            if (done)
            begin
                clock_hand = wrap_frame(vic, cnt);
            end
            else
            begin
                vic        = start;
                r.outcome  = ecvs_pkg::OC_FALLBACK;
                clock_hand = start;
            end
            r.victim = ecvs_pkg::VICTIM_W'(vic);
        end
        return r;
    endfunction

    task automatic send_request(input ecvs_pkg::op_t o, input logic [7:0] fr,
                                input logic occ, input logic dty, input bit fixed,
                                input logic [7:0] exp_victim,
                                input ecvs_pkg::outcome_t exp_outcome);
        reply_t r;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        frame    <= fr;
        occupied <= occ;
        dirty    <= dty;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_reply(o, fr, occ, dty);
        if (fixed)
        begin
            r.victim  = exp_victim;
            r.outcome = exp_outcome;
        end
        pending_replies.push_back(r);
    endtask

    task automatic send_random_request();
        ecvs_pkg::op_t o;
        logic [7:0]    fr;
        int            cnt;
        int            pick;
        cnt  = active_frames();
        pick = $urandom_range(99);
        if (pick < 30)
            o = ecvs_pkg::OP_SET_REF;
        else if (pick < 45)
            o = ecvs_pkg::OP_CLR_REF;
        else if (pick < 75)
            o = ecvs_pkg::OP_WR_STATUS;
        else
            o = ecvs_pkg::OP_SELECT;
        if (cnt > 0 && $urandom_range(9) != 0)
            fr = 8'($urandom_range(cnt - 1));
        else
            fr = 8'($urandom_range(255));
        send_request(o, fr, $urandom_range(3) != 0, $urandom_range(4) < 2,
                     1'b0, '0, ecvs_pkg::OC_ACK);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frame_count(input logic [ecvs_pkg::FC_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ecvs_pkg::REG_FRAME_COUNT, 2'b00};
        pwdata  <= ecvs_pkg::APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        frame_count_reg = value;
        clock_hand      = 0;
        foreach (ref_bit[k])
            ref_bit[k] = 1'b0;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== ecvs_pkg::APB_DW'(value))
        begin
            $error("frame_count readback: expected %0d, actual %0d", value, prdata);
            fail_cnt++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("reply with no request pending: victim %0d, outcome %0d",
                       victim, outcome);
                fail_cnt++;
            end
            else
            begin
                head = pending_replies.pop_front();
                if (victim !== head.victim)
                begin
                    $error("victim: expected %0d, actual %0d", head.victim, victim);
                    fail_cnt++;
                end
                if (outcome !== head.outcome)
                begin
                    $error("outcome: expected %0d, actual %0d", head.outcome, outcome);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        dir_row_t row;
        int       cnt;
        int       n_fill;
        int       seg;
        int       k;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        op              = ecvs_pkg::OP_SET_REF;
        frame           = '0;
        occupied        = 1'b0;
        dirty           = 1'b0;
        fail_cnt        = 0;
        clock_hand      = 0;
        frame_count_reg = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_cycles     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
        begin
            row = DIRECTED[k];
            if (row.is_cfg)
            begin
                wait_drained();
                write_frame_count(row.count);
            end
            else
            begin
                send_request(row.req_op, row.req_frame, row.req_occ, row.req_dty,
                             row.fixed, row.exp_victim, row.exp_outcome);
            end
        end

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_drained();
            write_frame_count(ecvs_pkg::FC_W'(seg_counts[seg]));
            case (seg % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 61;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 61;
                end
                default:
                begin
                    sender_idle_pct = 22;
                    recv_stall_pct  = 22;
                end
            endcase
            // hold the reply side off while requests keep coming
            if (seg == 6)
                hold_cycles = 300;
            cnt    = active_frames();
            n_fill = (cnt < 24) ? cnt : 24;
            for (k = 0; k < n_fill; k++)
            begin
                send_request(ecvs_pkg::OP_WR_STATUS,
                             (cnt <= 24) ? 8'(k) : 8'($urandom_range(cnt - 1)),
                             $urandom_range(3) != 0, $urandom_range(4) < 2,
                             1'b0, '0, ecvs_pkg::OC_ACK);
            end
            for (k = 0; k < 48; k++)
            begin
                if (seg == 9 && k == 24)
                    wait_drained();
                send_random_request();
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
